>>> hw/rtl/host_occurrence_table_macros.svh
// Assertion macros for the checker of the host table.
`ifndef HOST_OCCURRENCE_TABLE_MACROS_SVH
`define HOST_OCCURRENCE_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define HOT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define HOT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/hot_pkg.sv
`default_nettype none

package hot_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned SLOT_W = 6;

  localparam logic [1:0] OP_OBSERVE = 2'd0;
  localparam logic [1:0] OP_REMOVE  = 2'd1;
  localparam logic [1:0] OP_LOOKUP  = 2'd2;

  localparam logic [1:0] STATUS_HIT  = 2'd0;
  localparam logic [1:0] STATUS_NEW  = 2'd1;
  localparam logic [1:0] STATUS_MISS = 2'd2;
  localparam logic [1:0] STATUS_FULL = 2'd3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] first;
    logic [DATA_W-1:0] last;
    logic [DATA_W-1:0] count;
    logic [DATA_W-1:0] window;
  } rec_t;

endpackage

`default_nettype wire

>>> hw/rtl/host_occurrence_table.sv
`default_nettype none
// Host occurrence table: TABLE_ENTRIES records keyed by a 32-bit IPv4 address.
// Command channel: op_i, host_addr_i and now_i are taken at a rising edge with
// start high and busy low. op observe updates or inserts a record, remove
// frees it, lookup reports it (op 3 acts as lookup).
// Result channel: done_o is high for exactly one cycle with status_o, slot_o,
// count_o, first_time_o and last_time_o; the receiver cannot stall it.
// Config: cfg_we_i writes cfg_wdata_i into time_window; write only while idle.
// Timing: all records sit in one single-port-read memory that is scanned one
// entry per cycle from slot 0, and the scan ends early on a key match. done_o
// comes in the cycle after the write-back, and busy is already low then, so
// the next command may be accepted in that same cycle; no command is taken
// while one is in flight.
// Reset: a clearing pass over every slot, from slot 0 up, marks every record
// free; busy stays high until it ends. time_window resets to 0.
module host_occurrence_table #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                op_i,
  input  wire logic [hot_pkg::DATA_W-1:0] host_addr_i,
  input  wire logic [hot_pkg::DATA_W-1:0] now_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [hot_pkg::DATA_W-1:0] cfg_wdata_i,
  output logic                           done_o,
  output logic [1:0]                     status_o,
  output logic [hot_pkg::SLOT_W-1:0]     slot_o,
  output logic [hot_pkg::DATA_W-1:0]     count_o,
  output logic [hot_pkg::DATA_W-1:0]     first_time_o,
  output logic [hot_pkg::DATA_W-1:0]     last_time_o
);
  import hot_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  rec_t mem_q [TABLE_ENTRIES];
  rec_t rdata_q;

  state_e state_q, state_d;

  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              issued_all_q, issued_all_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]  cmp_idx_q, cmp_idx_d;
  logic              hit_q, hit_d;
  logic [IDX_W-1:0]  slot_q, slot_d;
  logic              free_found_q, free_found_d;
  logic [IDX_W-1:0]  free_q, free_d;
  rec_t              rec_q, rec_d;
  logic [1:0]        op_q, op_d;
  logic [DATA_W-1:0] key_q, key_d;
  logic [DATA_W-1:0] now_q, now_d;
  logic [DATA_W-1:0] window_q, window_d;

  logic              done_q, done_d;
  logic [1:0]        status_q, status_d;
  logic [SLOT_W-1:0] slot_out_q, slot_out_d;
  logic [DATA_W-1:0] count_q, count_d;
  logic [DATA_W-1:0] first_q, first_d;
  logic [DATA_W-1:0] last_q, last_d;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  rec_t              wdata;
  logic              cmp_hit;
  logic [DATA_W-1:0] age;
  logic              in_window;
  logic [DATA_W-1:0] count_inc;

  assign cmp_hit   = cmp_vld_q && rdata_q.valid && (rdata_q.key == key_q);
  assign age       = now_q - rec_q.first;
  assign in_window = (now_q < rec_q.first) || (age <= rec_q.window);
  assign count_inc = (in_window && (rec_q.count != '1)) ? rec_q.count + 1'b1 : rec_q.count;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (idx_q == LAST_IDX) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (cmp_hit || (cmp_vld_q && (cmp_idx_q == LAST_IDX))) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    idx_d        = idx_q;
    issued_all_d = issued_all_q;
    cmp_vld_d    = 1'b0;
    cmp_idx_d    = idx_q;
    hit_d        = hit_q;
    slot_d       = slot_q;
    free_found_d = free_found_q;
    free_d       = free_q;
    rec_d        = rec_q;
    op_d         = op_q;
    key_d        = key_q;
    now_d        = now_q;
    window_d     = cfg_we_i ? cfg_wdata_i : window_q;
    done_d       = 1'b0;
    status_d     = status_q;
    slot_out_d   = slot_out_q;
    count_d      = count_q;
    first_d      = first_q;
    last_d       = last_q;
    we           = 1'b0;
    waddr        = idx_q;
    wdata        = '0;

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        idx_d = idx_q + 1'b1;
      end
      ST_IDLE: begin
        if (start) begin
          idx_d        = '0;
          issued_all_d = 1'b0;
          hit_d        = 1'b0;
          free_found_d = 1'b0;
          op_d         = op_i;
          key_d        = host_addr_i;
          now_d        = now_i;
        end
      end
      ST_SCAN: begin
        if (!issued_all_q) begin
          idx_d        = idx_q + 1'b1;
          issued_all_d = (idx_q == LAST_IDX);
          cmp_vld_d    = 1'b1;
        end
        if (cmp_hit) begin
          hit_d  = 1'b1;
          slot_d = cmp_idx_q;
          rec_d  = rdata_q;
        end else if (cmp_vld_q && !rdata_q.valid && !free_found_q) begin
          free_found_d = 1'b1;
          free_d       = cmp_idx_q;
        end
      end
      ST_FINISH: begin
        done_d     = 1'b1;
        status_d   = STATUS_MISS;
        slot_out_d = '0;
        count_d    = '0;
        first_d    = '0;
        last_d     = '0;
        waddr      = hit_q ? slot_q : free_q;
        if (op_q == OP_OBSERVE) begin
          priority if (hit_q) begin
            we         = 1'b1;
            wdata      = rec_q;
            wdata.last = now_q;
            wdata.count = count_inc;
            status_d   = STATUS_HIT;
            slot_out_d = SLOT_W'(slot_q);
            count_d    = count_inc;
            first_d    = rec_q.first;
            last_d     = now_q;
          end else if (free_found_q) begin
            we           = 1'b1;
            wdata.valid  = 1'b1;
            wdata.key    = key_q;
            wdata.first  = now_q;
            wdata.last   = '0;
            wdata.count  = DATA_W'(1);
            wdata.window = window_q;
            status_d     = STATUS_NEW;
            slot_out_d   = SLOT_W'(free_q);
            count_d      = DATA_W'(1);
            first_d      = now_q;
          end else begin
            status_d = STATUS_FULL;
          end
        end else if (hit_q) begin
          we          = (op_q == OP_REMOVE);
          wdata       = rec_q;
          wdata.valid = 1'b0;
          status_d    = STATUS_HIT;
          slot_out_d  = SLOT_W'(slot_q);
          count_d     = rec_q.count;
          first_d     = rec_q.first;
          last_d      = rec_q.last;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      idx_q        <= '0;
      issued_all_q <= 1'b0;
      cmp_vld_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      window_q     <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      issued_all_q <= issued_all_d;
      cmp_vld_q    <= cmp_vld_d;
      hit_q        <= hit_d;
      free_found_q <= free_found_d;
      window_q     <= window_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q  <= cmp_idx_d;
    slot_q     <= slot_d;
    free_q     <= free_d;
    rec_q      <= rec_d;
    op_q       <= op_d;
    key_q      <= key_d;
    now_q      <= now_d;
    status_q   <= status_d;
    slot_out_q <= slot_out_d;
    count_q    <= count_d;
    first_q    <= first_d;
    last_q     <= last_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign status_o     = status_q;
  assign slot_o       = slot_out_q;
  assign count_o      = count_q;
  assign first_time_o = first_q;
  assign last_time_o  = last_q;

endmodule

`default_nettype wire

>>> hw/rtl/hot_checker.sv
`default_nettype none
`include "host_occurrence_table_macros.svh"

module hot_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        start,
  input wire logic                        busy,
  input wire logic                        done_o,
  input wire logic [1:0]                  status_o,
  input wire logic [hot_pkg::SLOT_W-1:0]  slot_o,
  input wire logic [hot_pkg::DATA_W-1:0]  count_o,
  input wire logic [hot_pkg::DATA_W-1:0]  first_time_o,
  input wire logic [hot_pkg::DATA_W-1:0]  last_time_o
);
  import hot_pkg::*;

  `HOT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  `HOT_ASSERT_NEXT(a_single_done, done_o, !done_o, "result word repeated")
  `HOT_ASSERT_NOW(a_empty_result,
    done_o && ((status_o == STATUS_MISS) || (status_o == STATUS_FULL)),
    (slot_o == '0) && (count_o == '0) && (first_time_o == '0) && (last_time_o == '0),
    "miss or full result carries record data")
  `HOT_ASSERT_NOW(a_new_record, done_o && (status_o == STATUS_NEW),
    (count_o == DATA_W'(1)) && (last_time_o == '0), "inserted record not fresh")

endmodule

bind host_occurrence_table hot_checker u_hot_checker (.*);

`default_nettype wire
